>>> rtl/longest_increasing_subsequence_lengths_defines.svh
// Assertion macros for the longest increasing subsequence block.
// Included by modules that check their own logic; expects clk and rst_n in scope.
`ifndef LONGEST_INCREASING_SUBSEQUENCE_LENGTHS_DEFINES_SVH
`define LONGEST_INCREASING_SUBSEQUENCE_LENGTHS_DEFINES_SVH

`ifndef SYNTHESIS
`define LISL_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("lisl assertion failed");
`define LISL_NEVER(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("lisl forbidden condition seen");
`else
`define LISL_ASSERT(lbl, prop)
`define LISL_NEVER(lbl, expr)
`endif

`endif

>>> rtl/lisl_pkg.sv
// Shared constants and types for the longest increasing subsequence block.
// Used by lisl_cell and longest_increasing_subsequence_lengths; no dependencies.
package lisl_pkg;

    localparam int MAX_ELEMENTS = 128;
    localparam int VAL_W        = 32;
    localparam int LEN_W        = 8;
    localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);

    localparam logic [LEN_W-1:0] LEN_MAX = '1;

    // Search word walking down the cell row
    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic [LEN_W-1:0]        best;
        logic [CNT_W-1:0]        rem;
        logic                    last;
    } tok_t;

    // Completion report of one cell
    typedef struct packed {
        logic             done;
        logic [LEN_W-1:0] run;
        logic             last;
    } res_t;

endpackage

>>> rtl/lisl_cell.sv
// One cell of the search row: stores one element and its run length.
// Depends on lisl_pkg; instantiated in a chain by the top level.
module lisl_cell (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        hold,
    input  logic        tok_vld_in,
    input  lisl_pkg::tok_t tok_in,
    output logic        tok_vld_out,
    output lisl_pkg::tok_t tok_out,
    output lisl_pkg::res_t res
);
    import lisl_pkg::*;

    logic                    tok_vld_reg;
    tok_t                    tok_reg;
    logic signed [VAL_W-1:0] val_reg;
    logic [LEN_W-1:0]        len_reg;
    logic                    hit;
    logic [LEN_W-1:0]        run;
    logic                    better;

    assign hit = tok_vld_reg && (tok_reg.rem == '0);
    assign run = (tok_reg.best == LEN_MAX) ? LEN_MAX : tok_reg.best + LEN_W'(1);

    // Stored entry counts only if strictly smaller and longer than best so far
    assign better = ($signed(val_reg) < $signed(tok_reg.value)) && (len_reg > tok_reg.best);

    always_comb
    begin
        tok_vld_out   = tok_vld_reg && !hit;
        tok_out.value = tok_reg.value;
        tok_out.best  = better ? len_reg : tok_reg.best;
        tok_out.rem   = tok_reg.rem - CNT_W'(1);
        tok_out.last  = tok_reg.last;
        res.done      = hit;
        res.run       = run;
        res.last      = tok_reg.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_vld_reg <= 1'b0;
        end
        else if (!hold)
        begin
            tok_vld_reg <= tok_vld_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!hold)
        begin
            tok_reg <= tok_in;
        end
        if (hit && !hold)
        begin
            val_reg <= tok_reg.value;
            len_reg <= run;
        end
    end

endmodule

>>> rtl/longest_increasing_subsequence_lengths.sv
// Longest strictly increasing subsequence lengths: top level with the cell row.
// Depends on lisl_pkg, lisl_cell and the defines header.
//
// Each accepted word is answered with the length of the longest strictly
// increasing run ending at it. Elements of the current sequence sit in a row of
// MAX_ELEMENTS cells; a new word enters cell 0 and walks one cell per cycle,
// except while a finished word waits on a stalled output, picking up the best
// length among smaller stored values, until it reaches the first free cell,
// where it is stored and reported. No further element is accepted until the
// walking one is stored. A word arriving with the row full is answered at
// once with overflow set and length 0. A word with last set closes the
// sequence. The result register lets the next word in while a finished
// result still waits to be taken.
`include "longest_increasing_subsequence_lengths_defines.svh"

module longest_increasing_subsequence_lengths (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [lisl_pkg::VAL_W-1:0] value,
    input  logic                              last,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [lisl_pkg::LEN_W-1:0]        run_length,
    output logic                              end_of_sequence,
    output logic                              overflow
);
    import lisl_pkg::*;

    logic [CNT_W-1:0]      count_reg, count_next;
    logic                  busy_reg, busy_next;
    logic                  out_vld_reg, out_vld_next;
    logic [LEN_W-1:0]      run_reg, run_next;
    logic                  eos_reg, eos_next;
    logic                  ovf_reg, ovf_next;

    logic                  full;
    logic                  accept;
    logic                  ovf_fire;
    logic                  done_fire;
    logic                  done_any;
    logic                  hold;
    logic [LEN_W-1:0]      done_run;
    logic                  done_last;

    logic [MAX_ELEMENTS:0] chain_vld;
    tok_t                  chain_tok [MAX_ELEMENTS+1];
    res_t                  cell_res  [MAX_ELEMENTS];
    logic [MAX_ELEMENTS-1:0] done_vec;

    assign full      = (count_reg == CNT_W'(MAX_ELEMENTS));
    assign in_stall  = busy_reg || (full && out_vld_reg && out_stall);
    assign accept    = in_valid && !in_stall;
    assign ovf_fire  = accept && full;
    assign hold      = done_any && out_vld_reg && out_stall;
    assign done_fire = done_any && !hold;

    // Inject the new word at the head of the row
    assign chain_vld[0]       = accept && !full;
    assign chain_tok[0].value = value;
    assign chain_tok[0].best  = '0;
    assign chain_tok[0].rem   = count_reg;
    assign chain_tok[0].last  = last;

    for (genvar i = 0; i < MAX_ELEMENTS; i++)
    begin : g_cell
        lisl_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .hold        (hold),
            .tok_vld_in  (chain_vld[i]),
            .tok_in      (chain_tok[i]),
            .tok_vld_out (chain_vld[i+1]),
            .tok_out     (chain_tok[i+1]),
            .res         (cell_res[i])
        );
        assign done_vec[i] = cell_res[i].done;
    end

    // At most one cell finishes at a time: OR the masked reports together
    always_comb
    begin
        done_run  = '0;
        done_last = 1'b0;
        for (int i = 0; i < MAX_ELEMENTS; i++)
        begin
            done_run  = done_run  | (cell_res[i].run & {LEN_W{cell_res[i].done}});
            done_last = done_last | (cell_res[i].last & cell_res[i].done);
        end
        done_any = |done_vec;
    end

    always_comb
    begin
        count_next   = count_reg;
        busy_next    = busy_reg;
        out_vld_next = out_vld_reg;
        run_next     = run_reg;
        eos_next     = eos_reg;
        ovf_next     = ovf_reg;

        if (out_vld_reg && !out_stall)
        begin
            out_vld_next = 1'b0;
        end

        if (accept && !full)
        begin
            busy_next = 1'b1;
        end

        if (ovf_fire)
        begin
            out_vld_next = 1'b1;
            run_next     = '0;
            eos_next     = last;
            ovf_next     = 1'b1;
            count_next   = last ? '0 : count_reg;
        end
        else if (done_fire)
        begin
            out_vld_next = 1'b1;
            run_next     = done_run;
            eos_next     = done_last;
            ovf_next     = 1'b0;
            busy_next    = 1'b0;
            count_next   = done_last ? '0 : count_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            busy_reg    <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            busy_reg    <= busy_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        run_reg <= run_next;
        eos_reg <= eos_next;
        ovf_reg <= ovf_next;
    end

    assign out_valid       = out_vld_reg;
    assign run_length      = run_reg;
    assign end_of_sequence = eos_reg;
    assign overflow        = ovf_reg;

    `LISL_NEVER(a_no_chain_overrun, chain_vld[MAX_ELEMENTS])
    `LISL_ASSERT(a_single_finisher, $onehot0(done_vec))
    `LISL_ASSERT(a_done_only_busy, done_any |-> busy_reg)
    `LISL_ASSERT(a_busy_not_full, busy_reg |-> (count_reg < CNT_W'(MAX_ELEMENTS)))
    `LISL_ASSERT(a_hold_freezes, hold |=> $stable(done_vec))

endmodule

>>> dv/testbench.sv
// Self-checking bench for longest_increasing_subsequence_lengths: directed table, then random
// sequences checked word by word against an in-bench length predictor.
// Depends on lisl_pkg and the RTL top level only.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import lisl_pkg::*;

    localparam int TARGET_WORDS   = 1300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLDOFF_CYCLES = 400;
    localparam int HOLDOFF_AFTER  = 150;
    localparam int QUIET_FIRST    = 500;
    localparam int QUIET_LAST     = 800;
    localparam int REPORT_LIMIT   = 10;

    typedef struct packed {
        logic [LEN_W-1:0] run;
        logic             eos;
        logic             ovf;
    } lis_word_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] v;
        logic                    lst;
        logic                    typed;
        logic [LEN_W-1:0]        run;
        logic                    ovf;
    } stim_row_t;

    typedef enum int {SHAPE_WIDE, SHAPE_NARROW, SHAPE_RISING, SHAPE_FALLING, SHAPE_EDGES} shape_t;

    localparam int DIRECTED_ROWS = 24;
    localparam stim_row_t DIRECTED [0:DIRECTED_ROWS-1] = '{
        '{32'h0000_0000, 1'b0, 1'b1, 8'd1, 1'b0},   // first word after reset
        '{32'h8000_0000, 1'b0, 1'b1, 8'd1, 1'b0},   // most negative value
        '{32'h7FFF_FFFF, 1'b0, 1'b0, 8'd0, 1'b0},
        '{32'h7FFF_FFFF, 1'b0, 1'b0, 8'd0, 1'b0},   // equal is not an increase
        '{32'h0000_0005, 1'b1, 1'b0, 8'd0, 1'b0},
        '{32'hFFFF_FFFF, 1'b0, 1'b1, 8'd1, 1'b0},   // fresh sequence
        '{32'hFFFF_FFFF, 1'b0, 1'b1, 8'd1, 1'b0},
        '{32'hFFFF_FFFE, 1'b0, 1'b1, 8'd1, 1'b0},
        '{32'h0000_0000, 1'b0, 1'b0, 8'd0, 1'b0},
        '{32'h0000_0001, 1'b1, 1'b0, 8'd0, 1'b0},
        '{32'h0000_0007, 1'b1, 1'b1, 8'd1, 1'b0},   // one-word sequences
        '{32'h7FFF_FFFF, 1'b1, 1'b1, 8'd1, 1'b0},
        '{32'h8000_0000, 1'b1, 1'b1, 8'd1, 1'b0},
        '{32'd10, 1'b0, 1'b0, 8'd0, 1'b0},
        '{32'd20, 1'b0, 1'b0, 8'd0, 1'b0},
        '{32'd30, 1'b0, 1'b0, 8'd0, 1'b0},
        '{32'd40, 1'b0, 1'b0, 8'd0, 1'b0},
        '{32'd50, 1'b0, 1'b0, 8'd0, 1'b0},
        '{32'd60, 1'b0, 1'b0, 8'd0, 1'b0},
        '{32'd70, 1'b0, 1'b0, 8'd0, 1'b0},
        '{32'd80, 1'b1, 1'b0, 8'd0, 1'b0},
        '{32'h5555_5555, 1'b0, 1'b1, 8'd1, 1'b0},
        '{32'hAAAA_AAAA, 1'b0, 1'b1, 8'd1, 1'b0},
        '{32'h5555_5555, 1'b1, 1'b0, 8'd0, 1'b0}
    };

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_stall;
    logic signed [VAL_W-1:0] value;
    logic                    last;
    logic                    out_valid;
    logic                    out_stall;
    logic [LEN_W-1:0]        run_length;
    logic                    end_of_sequence;
    logic                    overflow;

    // typed expectation travelling beside the payload
    logic                    exp_typed;
    logic [LEN_W-1:0]        exp_run;
    logic                    exp_ovf;

    // predictor state
    bit signed [VAL_W-1:0]   seq_values [MAX_ELEMENTS];
    bit [LEN_W-1:0]          seq_lengths [MAX_ELEMENTS];
    int unsigned             seq_count;

    lis_word_t               pending_lengths [$];
    int unsigned             words_in;
    int unsigned             words_out;
    int unsigned             words_sent;
    int unsigned             error_count;
    int unsigned             quiet_cycles;
    bit                      no_idle;

    longest_increasing_subsequence_lengths uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .value           (value),
        .last            (last),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .run_length      (run_length),
        .end_of_sequence (end_of_sequence),
        .overflow        (overflow)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic lis_word_t lis_length_of(logic signed [VAL_W-1:0] v, logic lst);
        lis_word_t   res;
        int unsigned best;
        res.run = '0;
        res.eos = lst;
        res.ovf = 1'b0;
        best = 0;
        if (seq_count >= MAX_ELEMENTS)
        begin
            res.ovf = 1'b1;
        end
        else
        begin
            for (int unsigned k = 0; k < seq_count; k++)
            begin
                if (seq_values[k] < v && seq_lengths[k] > best)
                    best = seq_lengths[k];
            end
            res.run = (best + 1 > LEN_MAX) ? LEN_MAX : LEN_W'(best + 1);
            seq_values[seq_count] = v;
            seq_lengths[seq_count] = res.run;
            seq_count++;
        end
        if (lst)
            seq_count = 0;
        return res;
    endfunction

    function automatic logic signed [VAL_W-1:0] pick_value(shape_t shape, int unsigned pos);
        case (shape)
            SHAPE_NARROW:  return VAL_W'(int'($urandom_range(15)) - 8);
            // step of 16 with jitter below 16 keeps the run strictly rising
            SHAPE_RISING:  return VAL_W'(pos * 16 + $urandom_range(15));
            SHAPE_FALLING: return VAL_W'(-int'(pos * 16) - int'($urandom_range(15)));
            SHAPE_EDGES:
            begin
                case ($urandom_range(4))
                    0:       return 32'h8000_0000;
                    1:       return 32'h7FFF_FFFF;
                    2:       return -32'sd1;
                    3:       return 32'sd0;
                    default: return 32'sd1;
                endcase
            end
            default:       return VAL_W'($urandom);
        endcase
    endfunction

    task automatic send_word(logic signed [VAL_W-1:0] v, logic lst, logic typed,
                             logic [LEN_W-1:0] run, logic ovf);
        no_idle = (words_sent >= QUIET_FIRST && words_sent < QUIET_LAST);
        while (!no_idle && $urandom_range(99) < 32)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        value     <= v;
        last      <= lst;
        exp_typed <= typed;
        exp_run   <= run;
        exp_ovf   <= ovf;
        do
            @(posedge clk);
        while (in_stall);
        words_sent++;
    endtask

    task automatic send_sequence(shape_t shape, int unsigned len, bit broken);
        for (int unsigned k = 0; k < len; k++)
        begin
            send_word(pick_value(shape, k), broken ? 1'($urandom_range(1)) : (k == len - 1),
                      1'b0, '0, 1'b0);
        end
    endtask

    // stimulus
    initial
    begin
        int unsigned seq_idx;
        shape_t      shape;
        rst_n      = 1'b0;
        in_valid   <= 1'b0;
        value      <= '0;
        last       <= 1'b0;
        exp_typed  <= 1'b0;
        exp_run    <= '0;
        exp_ovf    <= 1'b0;
        words_sent = 0;
        no_idle    = 1'b0;
        seq_count  = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < DIRECTED_ROWS; r++)
        begin
            send_word(DIRECTED[r].v, DIRECTED[r].lst, DIRECTED[r].typed,
                      DIRECTED[r].run, DIRECTED[r].ovf);
        end

        seq_idx = 0;
        while (words_sent < TARGET_WORDS)
        begin
            shape = shape_t'($urandom_range(4));
            // a few sequences fill the store exactly or run past it
            if (seq_idx == 3)
                send_sequence(SHAPE_RISING, MAX_ELEMENTS, 1'b0);
            else if (seq_idx == 20)
                send_sequence(SHAPE_NARROW, MAX_ELEMENTS + 1, 1'b0);
            else if (seq_idx == 40)
                send_sequence(SHAPE_WIDE, MAX_ELEMENTS + $urandom_range(2, 6), 1'b0);
            else if ($urandom_range(9) == 0)
                send_sequence(shape, $urandom_range(1, 6), 1'b1);
            else
                send_sequence(shape, $urandom_range(1, 24), 1'b0);
            seq_idx++;
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_lengths.size() != 0)
            @(posedge clk);
        repeat (MAX_ELEMENTS + 4) @(posedge clk);
        if (error_count == 0 && pending_lengths.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // receiver: random stall, one long hold-off so results back up and the input stalls
    initial
    begin
        int unsigned hold_left;
        bit          hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (!hold_done && words_in >= HOLDOFF_AFTER)
            begin
                hold_done = 1'b1;
                hold_left = HOLDOFF_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (no_idle)
            begin
                out_stall <= 1'b0;
            end
            else
            begin
                out_stall <= ($urandom_range(99) < 32);
            end
        end
    end

    // scoreboard and watchdog
    initial
    begin
        words_in     = 0;
        words_out    = 0;
        error_count  = 0;
        quiet_cycles = 0;
    end

    always @(posedge clk)
    begin
        lis_word_t predicted;
        lis_word_t oldest;
        if (rst_n)
        begin
            quiet_cycles++;
            if (in_valid && !in_stall)
            begin
                predicted = lis_length_of(value, last);
                if (exp_typed)
                begin
                    predicted.run = exp_run;
                    predicted.ovf = exp_ovf;
                end
                pending_lengths.push_back(predicted);
                words_in++;
                quiet_cycles = 0;
            end
            if (out_valid && !out_stall)
            begin
                quiet_cycles = 0;
                if (pending_lengths.size() == 0)
                begin
                    if (error_count < REPORT_LIMIT)
                        $display("word %0d: unexpected result run_length %0d eos %0b overflow %0b",
                                 words_out, run_length, end_of_sequence, overflow);
                    error_count++;
                end
                else
                begin
                    oldest = pending_lengths.pop_front();
                    if (run_length !== oldest.run || end_of_sequence !== oldest.eos
                        || overflow !== oldest.ovf)
                    begin
                        if (error_count < REPORT_LIMIT)
                            $display("word %0d: expected %0d %0b %0b, got %0d %0b %0b",
                                     words_out, oldest.run, oldest.eos, oldest.ovf,
                                     run_length, end_of_sequence, overflow);
                        error_count++;
                    end
                end
                words_out++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

endmodule
